// File: rtl/rca_pkg.sv
// Package for the reference-counted compacting allocator.
// Holds sizes, status and function codes and the sequencer state type.
// No dependencies.
`default_nettype none
package rca_pkg;

    localparam int unsigned POOL_BYTES_DEF  = 1024 * 512;
    localparam int unsigned MAX_OBJECTS_DEF = 64;
    localparam int unsigned COUNT_BITS_DEF  = 16;

    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned SIZE_W   = 20;
    localparam int unsigned ID_W     = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned OFFOUT_W = 19;
    localparam int unsigned NOBJ_W   = 7;
    localparam int unsigned CNTOUT_W = 16;

    typedef enum logic [1:0] {
        FN_INSERT   = 2'd0,
        FN_RETRIEVE = 2'd1,
        FN_ADD      = 2'd2,
        FN_DROP     = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOSPACE  = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_SAT      = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRD,
        S_SCMP,
        S_CRD,
        S_CWR,
        S_INS,
        S_SHRD,
        S_SHWR,
        S_DONE
    } state_t;

endpackage : rca_pkg
`default_nettype wire

// File: rtl/rca_ram.sv
// Generic single-port RAM with registered read.
// Used for the object table; no dependencies.
`default_nettype none
module rca_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule : rca_ram
`default_nettype wire

// File: rtl/refcount_compacting_allocator_unit.sv
// Top level of the reference-counted compacting allocator.
// Depends on rca_pkg and rca_ram.
`default_nettype none
// Usage: raise start with func, size and ref_id while busy is low; the item
// is taken at that edge and busy rises. Exactly one result follows, shown for
// one cycle with done high; the receiver cannot stall it, so it must take it.
// A table search reads the entries one at a time through the single port of
// the object table memory, in states S_SRD and S_SCMP per entry, for retrieve,
// add and drop; an absent id walks every live entry. A drop that frees an
// entry then moves each later entry down one place. An insert that needs
// compaction walks every live entry, with one shared adder accumulating the
// packed offsets. busy falls in the cycle after done, and the next item can
// be taken from that cycle on.
// Reset clears the live count, free pointer, buffer select and sets the next
// id to one; the table contents are not cleared since only entries below the
// live count are ever used.
module refcount_compacting_allocator_unit #(
    parameter int unsigned POOL_BYTES  = rca_pkg::POOL_BYTES_DEF,
    parameter int unsigned MAX_OBJECTS = rca_pkg::MAX_OBJECTS_DEF,
    parameter int unsigned COUNT_BITS  = rca_pkg::COUNT_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [rca_pkg::FUNC_W-1:0]   func,
    input  wire logic [rca_pkg::SIZE_W-1:0]   size,
    input  wire logic [rca_pkg::ID_W-1:0]     ref_id,
    output logic                         done,
    output logic [rca_pkg::STATUS_W-1:0] status,
    output logic [rca_pkg::ID_W-1:0]     new_id,
    output logic [rca_pkg::OFFOUT_W-1:0] offset,
    output logic                         active_buffer,
    output logic                         compacted,
    output logic [rca_pkg::NOBJ_W-1:0]   live_objects,
    output logic [rca_pkg::SIZE_W-1:0]   bytes_in_use,
    output logic [rca_pkg::SIZE_W-1:0]   bytes_freed,
    output logic                         removed,
    output logic [rca_pkg::CNTOUT_W-1:0] ref_count
);
    import rca_pkg::*;

    localparam int unsigned AW  = $clog2(MAX_OBJECTS);
    localparam int unsigned LW  = $clog2(MAX_OBJECTS + 1);
    // Pointer width: enough for POOL_BYTES plus a size, so sums never wrap.
    localparam int unsigned PW  = $clog2(POOL_BYTES + 1) + 1;
    localparam int unsigned EW  = ID_W + PW + PW + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    localparam logic [PW-1:0] POOL = PW'(POOL_BYTES);
    localparam logic [LW-1:0] LMAX = LW'(MAX_OBJECTS);

    typedef struct packed {
        logic [ID_W-1:0]       id;
        logic [PW-1:0]         off;
        logic [PW-1:0]         sz;
        logic [COUNT_BITS-1:0] cnt;
    } entry_t;

    state_t state_reg, state_next;
    logic [LW-1:0] live_reg, live_next;
    logic [PW-1:0] fp_reg, fp_next;
    logic [ID_W-1:0] nid_reg, nid_next;
    logic buf_reg, buf_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [PW-1:0] acc_reg, acc_next;
    logic [1:0] func_reg;
    logic [PW-1:0] size_reg;
    logic [ID_W-1:0] id_reg;

    logic [STATUS_W-1:0] st_reg, st_next;
    logic [ID_W-1:0] onid_reg, onid_next;
    logic [PW-1:0] ooff_reg, ooff_next;
    logic comp_reg, comp_next;
    logic [LW-1:0] nobj_reg, nobj_next;
    logic [PW-1:0] used_reg, used_next;
    logic [PW-1:0] freed_reg, freed_next;
    logic rem_reg, rem_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;

    logic ram_we;
    logic [AW-1:0] ram_addr;
    entry_t ram_wdata, ram_rdata;

    rca_ram #(.WIDTH(EW), .DEPTH(MAX_OBJECTS)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            live_reg  <= '0;
            fp_reg    <= '0;
            nid_reg   <= ID_W'(1);
            buf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            live_reg  <= live_next;
            fp_reg    <= fp_next;
            nid_reg   <= nid_next;
            buf_reg   <= buf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        acc_reg   <= acc_next;
        st_reg    <= st_next;
        onid_reg  <= onid_next;
        ooff_reg  <= ooff_next;
        comp_reg  <= comp_next;
        nobj_reg  <= nobj_next;
        used_reg  <= used_next;
        freed_reg <= freed_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        if (start && !busy)
        begin
            func_reg <= func;
            size_reg <= PW'(size);
            id_reg   <= ref_id;
        end
    end

    // The one shared adder: free pointer or accumulator plus a size.
    logic [PW-1:0] add_a, add_b, add_sum;
    assign add_sum = add_a + add_b;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (func == FN_INSERT) ? S_INS : S_SRD;
                end
            end
            S_SRD:  state_next = (idx_reg == live_reg) ? S_DONE : S_SCMP;
            S_SCMP:
            begin
                if (ram_rdata.id != id_reg)
                begin
                    state_next = S_SRD;
                end
                else if (func_reg == FN_DROP && ram_rdata.cnt == COUNT_BITS'(1))
                begin
                    state_next = S_SHRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_INS:
            begin
                if (live_reg >= LMAX || nid_reg == '0 || live_reg == '0
                    || comp_reg || add_sum <= POOL)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_CRD;
                end
            end
            S_CRD:  state_next = (idx_reg == live_reg) ? S_INS : S_CWR;
            S_CWR:  state_next = S_CRD;
            S_SHRD: state_next = (idx_reg == live_reg + LW'(1)) ? S_DONE : S_SHWR;
            S_SHWR: state_next = S_SHRD;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        live_next  = live_reg;
        fp_next    = fp_reg;
        nid_next   = nid_reg;
        buf_next   = buf_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        st_next    = st_reg;
        onid_next  = onid_reg;
        ooff_next  = ooff_reg;
        comp_next  = comp_reg;
        nobj_next  = nobj_reg;
        used_next  = used_reg;
        freed_next = freed_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        ram_we     = 1'b0;
        ram_addr   = idx_reg[AW-1:0];
        ram_wdata  = ram_rdata;
        add_a      = fp_reg;
        add_b      = size_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                idx_next   = '0;
                acc_next   = '0;
                st_next    = ST_NOTFOUND;
                onid_next  = '0;
                ooff_next  = '0;
                comp_next  = 1'b0;
                nobj_next  = '0;
                used_next  = '0;
                freed_next = '0;
                rem_next   = 1'b0;
                cnt_next   = '0;
            end
            S_SRD:
            begin
                idx_next = idx_reg + LW'(1);
            end
            S_SCMP:
            begin
                ram_addr = AW'(idx_reg - LW'(1));
                if (ram_rdata.id == id_reg)
                begin
                    st_next   = ST_OK;
                    ooff_next = ram_rdata.off;
                    unique case (func_reg)
                        FN_ADD:
                        begin
                            if (ram_rdata.cnt == CMAX)
                            begin
                                st_next  = ST_SAT;
                                cnt_next = ram_rdata.cnt;
                            end
                            else
                            begin
                                cnt_next      = ram_rdata.cnt + COUNT_BITS'(1);
                                ram_wdata.cnt = cnt_next;
                                ram_we        = 1'b1;
                            end
                        end
                        FN_DROP:
                        begin
                            cnt_next = ram_rdata.cnt - COUNT_BITS'(1);
                            if (cnt_next == '0)
                            begin
                                rem_next  = 1'b1;
                                live_next = live_reg - LW'(1);
                            end
                            else
                            begin
                                ram_wdata.cnt = cnt_next;
                                ram_we        = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SHRD:
            begin
                // idx points one past the removed slot; live already reduced.
                ram_addr = AW'(idx_reg);
                if (idx_reg != live_reg + LW'(1))
                begin
                    idx_next = idx_reg + LW'(1);
                end
            end
            S_SHWR:
            begin
                ram_addr = AW'(idx_reg - LW'(2));
                ram_we   = 1'b1;
            end
            S_CRD:
            begin
                if (idx_reg != live_reg)
                begin
                    idx_next = idx_reg + LW'(1);
                end
                else
                begin
                    comp_next  = 1'b1;
                    nobj_next  = live_reg;
                    used_next  = acc_reg;
                    freed_next = fp_reg - acc_reg;
                    fp_next    = acc_reg;
                    buf_next   = ~buf_reg;
                end
            end
            S_CWR:
            begin
                ram_addr      = AW'(idx_reg - LW'(1));
                ram_wdata.off = acc_reg;
                ram_we        = 1'b1;
                add_a         = acc_reg;
                add_b         = ram_rdata.sz;
                acc_next      = add_sum;
            end
            S_INS:
            begin
                ram_addr = AW'(live_reg);
                if (live_reg >= LMAX)
                begin
                    st_next = ST_FULL;
                end
                else if (nid_reg == '0)
                begin
                    st_next = ST_SAT;
                end
                else if (live_reg == '0 ? (size_reg > POOL) : (add_sum > POOL))
                begin
                    if (live_reg == '0 || comp_reg)
                    begin
                        st_next = ST_NOSPACE;
                    end
                end
                else
                begin
                    st_next       = ST_OK;
                    onid_next     = nid_reg;
                    ooff_next     = (live_reg == '0) ? '0 : fp_reg;
                    ram_wdata.id  = nid_reg;
                    ram_wdata.off = ooff_next;
                    ram_wdata.sz  = size_reg;
                    ram_wdata.cnt = COUNT_BITS'(1);
                    ram_we        = 1'b1;
                    live_next     = live_reg + LW'(1);
                    fp_next       = (live_reg == '0) ? size_reg : add_sum;
                    nid_next      = nid_reg + ID_W'(1);
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = (state_reg == S_DONE);
    assign status        = st_reg;
    assign new_id        = onid_reg;
    assign offset        = OFFOUT_W'(ooff_reg);
    assign active_buffer = buf_reg;
    assign compacted     = comp_reg;
    assign live_objects  = NOBJ_W'(nobj_reg);
    assign bytes_in_use  = SIZE_W'(used_reg);
    assign bytes_freed   = SIZE_W'(freed_reg);
    assign removed       = rem_reg;
    assign ref_count     = CNTOUT_W'(cnt_reg);
endmodule : refcount_compacting_allocator_unit
`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for refcount_compacting_allocator_unit.
// Depends on rca_pkg and the allocator RTL; a built-in table model predicts every result.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rca_pkg::*;

    localparam int unsigned POOL      = POOL_BYTES_DEF;
    localparam int unsigned SLOTS     = MAX_OBJECTS_DEF;
    localparam int unsigned COUNT_TOP = (1 << COUNT_BITS_DEF) - 1;

    // One request as presented on the command ports.
    typedef struct {
        func_t       fn;
        logic [19:0] sz;
        logic [31:0] id;
    } alloc_request_t;

    // One result as the block reports it.
    typedef struct {
        status_t     st;
        logic [31:0] nid;
        logic [18:0] off;
        logic        ab;
        logic        comp;
        logic [6:0]  nobj;
        logic [19:0] used;
        logic [19:0] freed;
        logic        rem;
        logic [15:0] cnt;
    } alloc_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  func = '0;
    logic [19:0] size = '0;
    logic [31:0] ref_id = '0;
    wire logic        busy;
    wire logic        done;
    wire logic [2:0]  status;
    wire logic [31:0] new_id;
    wire logic [18:0] offset;
    wire logic        active_buffer;
    wire logic        compacted;
    wire logic [6:0]  live_objects;
    wire logic [19:0] bytes_in_use;
    wire logic [19:0] bytes_freed;
    wire logic        removed;
    wire logic [15:0] ref_count;

    refcount_compacting_allocator_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .func(func), .size(size), .ref_id(ref_id),
        .done(done), .status(status), .new_id(new_id), .offset(offset),
        .active_buffer(active_buffer), .compacted(compacted),
        .live_objects(live_objects), .bytes_in_use(bytes_in_use),
        .bytes_freed(bytes_freed), .removed(removed), .ref_count(ref_count)
    );

    always #4 clk = ~clk;

    alloc_request_t pending_requests[$];
    alloc_result_t  expected_results[$];
    alloc_request_t on_port;
    int unsigned    sender_idle_pct = 0;
    int unsigned    err_count = 0;

    // Shadow copy of the object table, kept in allocation (and id) order.
    logic [31:0] obj_id[SLOTS];
    int unsigned obj_off[SLOTS];
    int unsigned obj_size[SLOTS];
    int unsigned obj_cnt[SLOTS];
    int unsigned obj_live = 0;
    int unsigned free_ptr = 0;
    logic [31:0] next_obj_id = 32'd1;
    logic        cur_buffer = 1'b0;

    task automatic place_object(input int unsigned at, input int unsigned sz);
        obj_id[obj_live]   = next_obj_id;
        obj_off[obj_live]  = at;
        obj_size[obj_live] = sz;
        obj_cnt[obj_live]  = 1;
        obj_live++;
        free_ptr    = at + sz;
        next_obj_id = next_obj_id + 32'd1;
    endtask

    // Applies one accepted request to the shadow table and queues its result.
    task automatic predict_allocator(input alloc_request_t rq);
        alloc_result_t r;
        int unsigned   slot;
        int unsigned   used;
        int unsigned   c;
        bit            hit;
        r = '{ST_OK, '0, '0, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0};
        if (rq.fn == FN_INSERT) begin
            if (obj_live >= SLOTS) begin
                r.st = ST_FULL;
            end
            else if (next_obj_id == 32'd0) begin
                r.st = ST_SAT;
            end
            else if (obj_live == 0) begin
                if (rq.sz > POOL) begin
                    r.st = ST_NOSPACE;
                end
                else begin
                    r.nid = next_obj_id;
                    place_object(0, rq.sz);
                end
            end
            else begin
                // Pool overflow packs every live object from zero and flips buffers.
                if (free_ptr + rq.sz > POOL) begin
                    used = 0;
                    for (int i = 0; i < obj_live; i++) begin
                        obj_off[i] = used;
                        used += obj_size[i];
                    end
                    r.comp  = 1'b1;
                    r.nobj  = obj_live;
                    r.used  = used;
                    r.freed = free_ptr - used;
                    free_ptr = used;
                    cur_buffer = ~cur_buffer;
                end
                if (free_ptr + rq.sz > POOL) begin
                    r.st = ST_NOSPACE;
                end
                else begin
                    r.nid = next_obj_id;
                    r.off = free_ptr;
                    place_object(free_ptr, rq.sz);
                end
            end
        end
        else begin
            hit = 1'b0;
            slot = 0;
            for (int i = 0; i < obj_live; i++) begin
                if (!hit && obj_id[i] == rq.id) begin
                    hit = 1'b1;
                    slot = i;
                end
            end
            if (!hit) begin
                r.st = ST_NOTFOUND;
            end
            else begin
                r.off = obj_off[slot];
                c = obj_cnt[slot];
                if (rq.fn == FN_ADD) begin
                    if (c >= COUNT_TOP) begin
                        r.st  = ST_SAT;
                        r.cnt = c;
                    end
                    else begin
                        obj_cnt[slot] = c + 1;
                        r.cnt = c + 1;
                    end
                end
                else if (rq.fn == FN_DROP) begin
                    c = c - 1;
                    if (c == 0) begin
                        // Later entries close up; the free pointer stays put.
                        for (int i = slot; i + 1 < obj_live; i++) begin
                            obj_id[i]   = obj_id[i + 1];
                            obj_off[i]  = obj_off[i + 1];
                            obj_size[i] = obj_size[i + 1];
                            obj_cnt[i]  = obj_cnt[i + 1];
                        end
                        obj_live--;
                        r.rem = 1'b1;
                    end
                    else begin
                        obj_cnt[slot] = c;
                        r.cnt = c;
                    end
                end
            end
        end
        r.ab = cur_buffer;
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_count < 40)
            $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what,
                     got, want);
        err_count++;
    endtask

    // Driver: a request is taken at an edge with start high and busy low. The
    // next one is presented at that same edge, so start is assigned only once.
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy)
                predict_allocator(on_port);
            if (!start || !busy) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    on_port = pending_requests.pop_front();
                    start  <= 1'b1;
                    func   <= on_port.fn;
                    size   <= on_port.sz;
                    ref_id <= on_port.id;
                end
                else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every done strobe must match the oldest outstanding prediction.
    always @(posedge clk) begin
        alloc_result_t w;
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", status, '0);
            end
            else begin
                w = expected_results.pop_front();
                if (status !== w.st)          report_mismatch("status", status, w.st);
                if (new_id !== w.nid)         report_mismatch("new_id", new_id, w.nid);
                if (offset !== w.off)         report_mismatch("offset", offset, w.off);
                if (active_buffer !== w.ab)   report_mismatch("active_buffer", active_buffer, w.ab);
                if (compacted !== w.comp)     report_mismatch("compacted", compacted, w.comp);
                if (live_objects !== w.nobj)  report_mismatch("live_objects", live_objects, w.nobj);
                if (bytes_in_use !== w.used)  report_mismatch("bytes_in_use", bytes_in_use, w.used);
                if (bytes_freed !== w.freed)  report_mismatch("bytes_freed", bytes_freed, w.freed);
                if (removed !== w.rem)        report_mismatch("removed", removed, w.rem);
                if (ref_count !== w.cnt)      report_mismatch("ref_count", ref_count, w.cnt);
            end
        end
    end

    task automatic queue_request(input func_t fn, input logic [19:0] sz,
                                 input logic [31:0] id);
        alloc_request_t rq;
        rq.fn = fn;
        rq.sz = sz;
        rq.id = id;
        pending_requests.push_back(rq);
    endtask

    // Mostly a live id from the shadow table, sometimes an absent or wild one.
    function automatic logic [31:0] choose_id();
        int unsigned pick;
        pick = $urandom_range(99);
        if (obj_live > 0 && pick < 85)
            return obj_id[$urandom_range(obj_live - 1)];
        if (pick < 92)
            return next_obj_id + $urandom_range(3);
        return $urandom();
    endfunction

    function automatic logic [19:0] choose_size();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5)  return 20'd0;
        if (pick < 70) return $urandom_range(16384);
        if (pick < 88) return $urandom_range(131072);
        if (pick < 97) return $urandom_range(POOL);
        return $urandom_range(20'hFFFFF, POOL + 1);
    endfunction

    initial begin
        func_t       fn;
        int unsigned pick;
        int unsigned ins_w;
        int unsigned drop_w;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        sender_idle_pct = 16;

        // Directed opening: oversized insert into an empty pool, zero sizes,
        // an offset at the very end of the pool, a failed insert that still
        // compacts, every lookup kind on live and absent ids, and a removal.
        queue_request(FN_INSERT, 20'hFFFFF, '0);
        queue_request(FN_INSERT, 20'd0, '0);
        queue_request(FN_INSERT, POOL, '0);
        queue_request(FN_INSERT, 20'd0, '0);
        queue_request(FN_INSERT, 20'd1, '0);
        queue_request(FN_RETRIEVE, '0, 32'd2);
        queue_request(FN_ADD, '0, 32'd2);
        queue_request(FN_DROP, '0, 32'd2);
        queue_request(FN_DROP, '0, 32'd2);
        queue_request(FN_RETRIEVE, '0, 32'd2);
        queue_request(FN_ADD, '0, 32'd2);
        queue_request(FN_DROP, '0, 32'hFFFFFFFF);
        queue_request(FN_RETRIEVE, '0, 32'd0);
        queue_request(FN_INSERT, 20'd100, '0);
        queue_request(FN_RETRIEVE, '0, 32'd3);
        queue_request(FN_DROP, '0, 32'd3);

        // Remove the first object from slot zero, then try to add to it.
        queue_request(FN_DROP, '0, 32'd1);
        queue_request(FN_ADD, '0, 32'd1);

        // Random part: alternate insert-heavy stretches that fill the table and
        // the pool with drop-heavy ones that empty it again.
        for (int n = 0; n < 1900; n++) begin
            sender_idle_pct = (n < 633) ? 16 : (n < 1266) ? 79 : 0;
            while (pending_requests.size() > 1) @(posedge clk);
            if ((n / 250) % 2 == 0) begin
                ins_w = 60;
                drop_w = 20;
            end
            else begin
                ins_w = 15;
                drop_w = 60;
            end
            pick = $urandom_range(99);
            if (pick < ins_w)               fn = FN_INSERT;
            else if (pick < ins_w + drop_w) fn = FN_DROP;
            else if (pick % 2 == 0)         fn = FN_ADD;
            else                            fn = FN_RETRIEVE;
            // Non-insert requests carry random size bits too, which must be ignored.
            queue_request(fn, (fn == FN_INSERT) ? choose_size() : 20'($urandom()),
                          (fn == FN_INSERT) ? 32'($urandom()) : choose_id());
        end

        while (pending_requests.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (err_count == 0 && expected_results.size() == 0)
            $display("refcount_compacting_allocator_unit verification clean");
        else
            $display("refcount_compacting_allocator_unit verification failed");
        $finish;
    end

    initial begin
        #60ms;
        $display("refcount_compacting_allocator_unit verification failed");
        $finish;
    end
endmodule
`default_nettype wire
